FILE: rtl/core/rgb_to_hsv_unit_assert.svh
// ----------------------------------------------------------------------------
// RGB to HSV unit assertion macros
// Shared assertion forms for the checker of the RGB to HSV unit.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_UNIT_ASSERT_SVH
`define RGB_TO_HSV_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RGBHSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define RGBHSV_NEVER(label, cond, msg) \
  `RGBHSV_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/core/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV package
// Angles, field widths and shared types of the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int HUE_SECTOR_DEG = 60;
  localparam int HUE_GREEN_DEG  = 120;
  localparam int HUE_BLUE_DEG   = 240;
  localparam int HUE_FULL_DEG   = 360;

  localparam int HUE_OUT_W = 15;
  localparam int SAT_OUT_W = 8;
  localparam int VAL_OUT_W = 8;

  // Register stages in front of the dividers.
  localparam int PREP_STAGES = 3;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_RED_WRAP,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_e;

  typedef struct packed {
    logic gray;
    logic black;
  } pix_flags_t;

  // Quotient width shared by both dividers, so that they have equal latency.
  function automatic int quot_width(input int chan_bits, input int frac_bits);
    int hue_w;
    hue_w = $clog2(HUE_FULL_DEG * (1 << frac_bits) + 1);
    return (hue_w > chan_bits) ? hue_w : chan_bits;
  endfunction

endpackage

FILE: rtl/core/rgbhsv_prep.sv
// ----------------------------------------------------------------------------
// RGB to HSV operand preparation
// Three register stages: extremes and sector, difference and scaled channel
// difference, then the dividends and divisors of hue and saturation.
// ----------------------------------------------------------------------------
module rgbhsv_prep #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 6,
  parameter int NUM_W         = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [CHANNEL_BITS-1:0]     red_i,
  input  logic [CHANNEL_BITS-1:0]     green_i,
  input  logic [CHANNEL_BITS-1:0]     blue_i,
  output logic                        valid_o,
  output logic [NUM_W-1:0]            hue_num_o,
  output logic [CHANNEL_BITS:0]       hue_den_o,
  output logic [NUM_W-1:0]            sat_num_o,
  output logic [CHANNEL_BITS:0]       sat_den_o,
  output logic [CHANNEL_BITS-1:0]     value_o,
  output rgbhsv_pkg::pix_flags_t      flags_o
);

  localparam int C       = CHANNEL_BITS;
  localparam int NUM60_W = C + 7;
  localparam int TOT_W   = C + 9;
  localparam int TOTS_W  = TOT_W + 1;
  localparam int NH_W    = C + HUE_FRAC_BITS + 11;
  localparam int NS_W    = 2 * C + 2;

  // Stage A: maximum, minimum, sector and signed channel difference.
  logic [C-1:0]        max_rg, min_rg, a_mx_d, a_mn_d;
  rgbhsv_pkg::sector_e a_sec_d;
  logic signed [C:0]   a_num_d;

  logic                a_valid_q;
  logic [C-1:0]        a_mx_q, a_mn_q;
  rgbhsv_pkg::sector_e a_sec_q;
  logic signed [C:0]   a_num_q;

  always_comb begin
    max_rg = (green_i > red_i) ? green_i : red_i;
    a_mx_d = (blue_i > max_rg) ? blue_i : max_rg;
    min_rg = (green_i < red_i) ? green_i : red_i;
    a_mn_d = (blue_i < min_rg) ? blue_i : min_rg;
    // Blue wins ties over green, and green over red.
    if (a_mx_d == blue_i) begin
      a_sec_d = rgbhsv_pkg::SECTOR_BLUE;
      a_num_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end else if (a_mx_d == green_i) begin
      a_sec_d = rgbhsv_pkg::SECTOR_GREEN;
      a_num_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      a_sec_d = (green_i < blue_i) ? rgbhsv_pkg::SECTOR_RED_WRAP : rgbhsv_pkg::SECTOR_RED;
      a_num_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mx_q  <= a_mx_d;
    a_mn_q  <= a_mn_d;
    a_sec_q <= a_sec_d;
    a_num_q <= a_num_d;
  end

  // Stage B: spread and sixty times the channel difference.
  logic [C-1:0]              b_d_d;
  logic signed [NUM60_W-1:0] b_num60_d;

  logic                      b_valid_q;
  logic [C-1:0]              b_d_q, b_mx_q;
  rgbhsv_pkg::sector_e       b_sec_q;
  logic signed [NUM60_W-1:0] b_num60_q;

  assign b_d_d     = a_mx_q - a_mn_q;
  assign b_num60_d = NUM60_W'(a_num_q) * NUM60_W'(rgbhsv_pkg::HUE_SECTOR_DEG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_d_q     <= b_d_d;
    b_mx_q    <= a_mx_q;
    b_sec_q   <= a_sec_q;
    b_num60_q <= b_num60_d;
  end

  // Stage C: sector base added in, then the rounded-division operands.
  logic [TOT_W-1:0]         d_ext, base_d, total;
  logic signed [TOTS_W-1:0] total_s;
  logic [NH_W-1:0]          nh;
  logic [NS_W-1:0]          ns;

  logic                     c_valid_q;
  logic [NUM_W-1:0]         c_hue_num_q, c_sat_num_q;
  logic [C:0]               c_hue_den_q, c_sat_den_q;
  logic [C-1:0]             c_value_q;
  rgbhsv_pkg::pix_flags_t   c_flags_q;

  always_comb begin
    d_ext = TOT_W'(b_d_q);
    unique case (b_sec_q)
      rgbhsv_pkg::SECTOR_RED:      base_d = '0;
      rgbhsv_pkg::SECTOR_RED_WRAP: base_d = d_ext * TOT_W'(rgbhsv_pkg::HUE_FULL_DEG);
      rgbhsv_pkg::SECTOR_GREEN:    base_d = d_ext * TOT_W'(rgbhsv_pkg::HUE_GREEN_DEG);
      rgbhsv_pkg::SECTOR_BLUE:     base_d = d_ext * TOT_W'(rgbhsv_pkg::HUE_BLUE_DEG);
      default:                     base_d = '0;
    endcase
    // The sum is never negative, so its low bits are the unsigned total.
    total_s = $signed({1'b0, base_d}) + TOTS_W'(b_num60_q);
    total   = total_s[TOT_W-1:0];
    nh = (NH_W'(total) << (HUE_FRAC_BITS + 1)) + NH_W'(b_d_q);
    ns = (NS_W'(b_d_q) << (C + 1)) - (NS_W'(b_d_q) << 1) + NS_W'(b_mx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_hue_num_q     <= NUM_W'(nh);
    c_hue_den_q     <= {b_d_q, 1'b0};
    c_sat_num_q     <= NUM_W'(ns);
    c_sat_den_q     <= {b_mx_q, 1'b0};
    c_value_q       <= b_mx_q;
    c_flags_q.gray  <= (b_d_q == '0);
    c_flags_q.black <= (b_mx_q == '0);
  end

  assign valid_o   = c_valid_q;
  assign hue_num_o = c_hue_num_q;
  assign hue_den_o = c_hue_den_q;
  assign sat_num_o = c_sat_num_q;
  assign sat_den_o = c_sat_den_q;
  assign value_o   = c_value_q;
  assign flags_o   = c_flags_q;

endmodule

FILE: rtl/core/rgbhsv_div.sv
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division, one quotient bit per register stage, with a payload
// that travels alongside each beat.
// ----------------------------------------------------------------------------
module rgbhsv_div #(
  parameter int DEN_W = 9,
  parameter int QUO_W = 15,
  parameter int PAY_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [QUO_W+DEN_W-1:0]   dividend_i,
  input  logic [DEN_W-1:0]         divisor_i,
  input  logic [PAY_W-1:0]         payload_i,
  output logic                     valid_o,
  output logic [QUO_W-1:0]         quotient_o,
  output logic [PAY_W-1:0]         payload_o
);

  localparam int NUM_W = QUO_W + DEN_W;

  // The quotient is known to fit in QUO_W bits, so the top part of the
  // dividend is already below the divisor and seeds the remainder.
  logic             vld_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [PAY_W-1:0] pay_q [QUO_W];
  logic [DEN_W-1:0] rem_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];
  logic [QUO_W-1:0] low_q [QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] rem_in, den_in;
    logic [QUO_W-1:0] low_in, quo_in;
    logic [PAY_W-1:0] pay_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = dividend_i[NUM_W-1:QUO_W];
      assign den_in = divisor_i;
      assign low_in = dividend_i[QUO_W-1:0];
      assign quo_in = '0;
      assign pay_in = payload_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign pay_in = pay_q[k-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[k] <= {quo_in[QUO_W-2:0], ge};
      pay_q[k] <= pay_in;
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        den_q[k] <= den_in;
        low_q[k] <= low_in << 1;
      end
    end
  end

  assign valid_o    = vld_q[QUO_W-1];
  assign quotient_o = quo_q[QUO_W-1];
  assign payload_o  = pay_q[QUO_W-1];

endmodule

FILE: rtl/core/rgb_to_hsv_unit.sv
// ----------------------------------------------------------------------------
// RGB to HSV unit
// Converts one RGB pixel per clock to hue, saturation and value.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Ports
//   --------  -------------------  ----------------------------------------
//   pixel in  start, busy          red_i, green_i, blue_i
//   result    valid_o (strobe)     hue_o, saturation_o, value_o
//
// A beat enters in every cycle; busy stays low.
// The pipeline runs through the PREP_STAGES operand stages, then Q divider stages,
// one quotient bit each, and the output register. Q, the divider quotient width,
// is max($clog2(360 * 2**HUE_FRAC_BITS + 1), CHANNEL_BITS), 15 at the defaults.
// Reset clears every valid bit in the pipeline; the payload is not reset.
// The receiver cannot stall, so each result shows for exactly one cycle.
//
module rgb_to_hsv_unit #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [CHANNEL_BITS-1:0]           red_i,
  input  logic [CHANNEL_BITS-1:0]           green_i,
  input  logic [CHANNEL_BITS-1:0]           blue_i,
  output logic                              valid_o,
  output logic [rgbhsv_pkg::HUE_OUT_W-1:0]  hue_o,
  output logic [rgbhsv_pkg::SAT_OUT_W-1:0]  saturation_o,
  output logic [rgbhsv_pkg::VAL_OUT_W-1:0]  value_o
);

  localparam int C        = CHANNEL_BITS;
  localparam int QUO_W    = rgbhsv_pkg::quot_width(CHANNEL_BITS, HUE_FRAC_BITS);
  localparam int DEN_W    = C + 1;
  localparam int NUM_W    = QUO_W + DEN_W;
  localparam int HUE_TURN = rgbhsv_pkg::HUE_FULL_DEG << HUE_FRAC_BITS;
  localparam int HUE_W    = rgbhsv_pkg::HUE_OUT_W;
  localparam int SAT_W    = rgbhsv_pkg::SAT_OUT_W;
  localparam int VAL_W    = rgbhsv_pkg::VAL_OUT_W;

  logic                   accept;
  logic                   prep_valid;
  logic [NUM_W-1:0]       hue_num, sat_num;
  logic [DEN_W-1:0]       hue_den, sat_den;
  logic [C-1:0]           prep_value;
  rgbhsv_pkg::pix_flags_t prep_flags;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  rgbhsv_prep #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .NUM_W         (NUM_W)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .valid_o   (prep_valid),
    .hue_num_o (hue_num),
    .hue_den_o (hue_den),
    .sat_num_o (sat_num),
    .sat_den_o (sat_den),
    .value_o   (prep_value),
    .flags_o   (prep_flags)
  );

  // The hue divider carries the value and the gray flag, the saturation
  // divider the black flag.
  logic             hue_valid, sat_valid;
  logic [QUO_W-1:0] hue_quo, sat_quo;
  logic [C:0]       hue_pay;
  logic             sat_black;

  rgbhsv_div #(
    .DEN_W (DEN_W),
    .QUO_W (QUO_W),
    .PAY_W (C + 1)
  ) u_hue_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (prep_valid),
    .dividend_i (hue_num),
    .divisor_i  (hue_den),
    .payload_i  ({prep_value, prep_flags.gray}),
    .valid_o    (hue_valid),
    .quotient_o (hue_quo),
    .payload_o  (hue_pay)
  );

  rgbhsv_div #(
    .DEN_W (DEN_W),
    .QUO_W (QUO_W),
    .PAY_W (1)
  ) u_sat_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (prep_valid),
    .dividend_i (sat_num),
    .divisor_i  (sat_den),
    .payload_i  (prep_flags.black),
    .valid_o    (sat_valid),
    .quotient_o (sat_quo),
    .payload_o  (sat_black)
  );

  // Output stage: a hue rounded up to a full turn wraps to zero.
  logic [QUO_W-1:0] hue_wrap;
  logic             out_valid_d, out_valid_q;
  logic [HUE_W-1:0] hue_d, hue_q;
  logic [SAT_W-1:0] sat_d, sat_q;
  logic [VAL_W-1:0] val_d, val_q;

  always_comb begin
    hue_wrap    = (hue_quo >= QUO_W'(HUE_TURN)) ? hue_quo - QUO_W'(HUE_TURN) : hue_quo;
    out_valid_d = hue_valid & sat_valid;
    hue_d       = hue_pay[0] ? '0 : HUE_W'(hue_wrap);
    sat_d       = sat_black ? '0 : SAT_W'(sat_quo);
    val_d       = VAL_W'(hue_pay[C:1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q <= hue_d;
    sat_q <= sat_d;
    val_q <= val_d;
  end

  assign valid_o      = out_valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = val_q;

endmodule

FILE: rtl/core/rgbhsv_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSV port checker
// Watches the ports of the RGB to HSV unit for latency and black pixels.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_unit_assert.svh"

module rgbhsv_checker #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 6
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              valid_o,
  input logic [rgbhsv_pkg::HUE_OUT_W-1:0]  hue_o,
  input logic [rgbhsv_pkg::SAT_OUT_W-1:0]  saturation_o,
  input logic [rgbhsv_pkg::VAL_OUT_W-1:0]  value_o
);

  localparam int LAT = rgbhsv_pkg::PREP_STAGES
                     + rgbhsv_pkg::quot_width(CHANNEL_BITS, HUE_FRAC_BITS) + 1;

  // A black pixel has neither saturation nor hue, where value is not truncated.
  logic black_coloured;

  assign black_coloured = valid_o && (CHANNEL_BITS <= 8) && (value_o == '0)
                          && ((saturation_o != '0) || (hue_o != '0));

  // Every accepted beat yields exactly one result after the fixed latency.
  `RGBHSV_ASSERT(a_beat_delivered, (start && !busy) |-> ##LAT valid_o, "beat lost in pipeline")
  `RGBHSV_ASSERT(a_no_extra_result, !(start && !busy) |-> ##LAT !valid_o, "result without a beat")

  `RGBHSV_NEVER(a_black_pixel, black_coloured, "black pixel with colour")

endmodule

bind rgb_to_hsv_unit rgbhsv_checker #(
  .CHANNEL_BITS  (CHANNEL_BITS),
  .HUE_FRAC_BITS (HUE_FRAC_BITS)
) u_rgbhsv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .value_o      (value_o)
);
